// ===== sv/basu_pkg.sv =====
package basu_pkg;

    // Default sizing, handed to the top level's parameters
    localparam int DEF_VERTEX_COUNT = 16;
    localparam int DEF_TRAIL_DEPTH  = 256;
    localparam int DEF_MAX_LEVELS   = 64;

    // Command codes
    localparam logic [1:0] CMD_NEW_LEVEL = 2'd0;
    localparam logic [1:0] CMD_ASSERT    = 2'd1;
    localparam logic [1:0] CMD_BACKJUMP  = 2'd2;
    localparam logic [1:0] CMD_READ      = 2'd3;

    // Relation codes
    localparam logic [2:0] REL_EQ       = 3'd0;
    localparam logic [2:0] REL_DISTINCT = 3'd1;
    localparam logic [2:0] REL_GE       = 3'd2;
    localparam logic [2:0] REL_LE       = 3'd3;
    localparam logic [2:0] REL_GT       = 3'd4;
    localparam logic [2:0] REL_LT       = 3'd5;

    // Status codes
    localparam logic [2:0] STS_OK          = 3'd0;
    localparam logic [2:0] STS_REJECT      = 3'd1;
    localparam logic [2:0] STS_BAD_LEVEL   = 3'd2;
    localparam logic [2:0] STS_TRAIL_FULL  = 3'd3;
    localparam logic [2:0] STS_NO_LEVEL    = 3'd4;
    localparam logic [2:0] STS_LEVELS_FULL = 3'd5;

    // Entry values
    localparam logic [1:0] ENT_UNKNOWN = 2'd0;
    localparam logic [1:0] ENT_ZERO    = 2'd1;
    localparam logic [1:0] ENT_ONE     = 2'd2;

    typedef enum logic [1:0] {
        DEC_ZERO,
        DEC_ONE,
        DEC_KEEP,
        DEC_BAD
    } dec_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_UNDO,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] row;
        logic [3:0] column;
        logic [2:0] relation;
        logic [7:0] literal_value;
        logic [6:0] target_level;
    } in_t;

    typedef struct packed {
        logic [1:0] entry_value;
        logic [2:0] status;
        logic [6:0] level_count;
        logic [8:0] undone_count;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic commit;
        logic undo_step;
        logic finish;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic bj_go;
        logic undo_busy;
        logic out_free;
    } ctrl_stat_t;

    // Turn a relation and a literal into the change it asks for
    function automatic dec_t decode_literal(input logic [2:0] relation,
                                            input logic [7:0] literal_value);
        dec_t d;
        logic v;
        v = literal_value[0];
        if (literal_value[7:1] != 7'd0) begin
            d = DEC_BAD;
        end else begin
            unique case (relation)
                REL_EQ:       d = v ? DEC_ONE  : DEC_ZERO;
                REL_DISTINCT: d = v ? DEC_ZERO : DEC_ONE;
                REL_GE:       d = v ? DEC_ONE  : DEC_KEEP;
                REL_LE:       d = v ? DEC_KEEP : DEC_ZERO;
                REL_GT:       d = v ? DEC_BAD  : DEC_ONE;
                REL_LT:       d = v ? DEC_ZERO : DEC_BAD;
                default:      d = DEC_BAD;
            endcase
        end
        return d;
    endfunction

    function automatic logic [1:0] dec_value(input dec_t d);
        logic [1:0] v;
        unique case (d)
            DEC_ZERO: v = ENT_ZERO;
            DEC_ONE:  v = ENT_ONE;
            default:  v = ENT_UNKNOWN;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/basu_ram.sv =====
module basu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/basu_ctrl.sv =====
module basu_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  basu_pkg::ctrl_stat_t stat,
    output basu_pkg::ctrl_cmd_t  cmd
);
    import basu_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.bj_go) begin
                    state_next = ST_UNDO;
                end else if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_UNDO: begin
                cmd.undo_step = 1'b1;
                if (!stat.undo_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

`ifndef SYNTH
    a_load_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_EXEC)
        else $error("accepted item did not move to execute");

    a_finish_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |-> !stat.undo_busy)
        else $error("backjump finishing with undo work left");

    a_ready_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("ready raised outside idle");
`endif

endmodule

// ===== sv/basu_dp.sv =====
module basu_dp #(
    parameter int VERTEX_COUNT = basu_pkg::DEF_VERTEX_COUNT,
    parameter int TRAIL_DEPTH  = basu_pkg::DEF_TRAIL_DEPTH,
    parameter int MAX_LEVELS   = basu_pkg::DEF_MAX_LEVELS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  basu_pkg::ctrl_cmd_t  cmd,
    output basu_pkg::ctrl_stat_t stat,
    input  basu_pkg::in_t        s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output basu_pkg::out_t       m_payload
);
    import basu_pkg::*;

    localparam int CELLS = VERTEX_COUNT * VERTEX_COUNT;
    localparam int IW    = $clog2(CELLS);
    localparam int RW    = IW + 2;
    localparam int TAW   = $clog2(TRAIL_DEPTH);
    localparam int TCW   = $clog2(TRAIL_DEPTH + 1);
    localparam int MAW   = $clog2(MAX_LEVELS);
    localparam int LW    = $clog2(MAX_LEVELS + 1);
    localparam int CMPW  = (LW > 8) ? LW : 8;

    localparam logic [TCW-1:0] TRAIL_FULL_C  = TCW'(TRAIL_DEPTH);
    localparam logic [LW-1:0]  LEVELS_FULL_C = LW'(MAX_LEVELS);
    localparam logic [IW-1:0]  CLR_LAST      = IW'(CELLS - 1);
    localparam logic [6:0]     NV_W          = 7'(VERTEX_COUNT);

    // Registers
    in_t             item_reg, item_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            in_range_reg, in_range_next;
    logic [TCW-1:0]  trail_count_reg, trail_count_next;
    logic [LW-1:0]   open_levels_reg, open_levels_next;
    logic [TCW-1:0]  undone_reg, undone_next;
    logic            pend_reg, pend_next;
    logic [IW-1:0]   clr_cnt_reg, clr_cnt_next;
    out_t            out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    // Memory ports
    logic            mat_we, mat_re;
    logic [IW-1:0]   mat_waddr, mat_raddr;
    logic [1:0]      mat_wdata, mat_rdata;
    logic            trl_we, trl_re;
    logic [TAW-1:0]  trl_waddr, trl_raddr;
    logic [RW-1:0]   trl_wdata, trl_rdata;
    logic            mrk_we, mrk_re;
    logic [MAW-1:0]  mrk_waddr, mrk_raddr;
    logic [TCW-1:0]  mrk_rdata;

    // Incoming item
    logic [IW-1:0]   s_idx;
    logic            s_in_range;
    logic [CMPW-1:0] s_tgt_p1;

    // Execute phase
    dec_t            dec;
    logic [1:0]      dec_val;
    logic [1:0]      old_val;
    logic            asrt_bad, asrt_change, asrt_write;
    logic            no_level, trail_full, levels_full, bj_bad;
    logic [CMPW-1:0] tgt_p1;
    logic            undo_more;
    logic [1:0]      res_entry;
    logic [2:0]      res_status;
    logic [LW-1:0]   open_after;

    assign s_idx      = IW'(s_payload.row) * IW'(VERTEX_COUNT) + IW'(s_payload.column);
    assign s_in_range = ({3'b000, s_payload.row} < NV_W) && ({3'b000, s_payload.column} < NV_W);
    assign s_tgt_p1   = CMPW'(s_payload.target_level) + CMPW'(1);

    assign old_val     = mat_rdata;
    assign dec         = decode_literal(item_reg.relation, item_reg.literal_value);
    assign dec_val     = dec_value(dec);
    assign tgt_p1      = CMPW'(item_reg.target_level) + CMPW'(1);
    assign no_level    = (open_levels_reg == '0);
    assign trail_full  = (trail_count_reg >= TRAIL_FULL_C);
    assign levels_full = (open_levels_reg >= LEVELS_FULL_C);
    assign asrt_bad    = (dec == DEC_BAD) || !in_range_reg;
    assign asrt_change = !asrt_bad && (dec != DEC_KEEP) && (dec_val != old_val);
    assign asrt_write  = asrt_change && !no_level && !trail_full;
    assign bj_bad      = no_level || (tgt_p1 >= CMPW'(open_levels_reg));
    assign undo_more   = (trail_count_reg > mrk_rdata);

    assign stat.clear_last = (clr_cnt_reg == CLR_LAST);
    assign stat.bj_go      = (item_reg.command == CMD_BACKJUMP) && !bj_bad;
    assign stat.undo_busy  = undo_more || pend_reg;
    assign stat.out_free   = !out_valid_reg || m_ready;

    always_comb begin
        res_entry  = ENT_UNKNOWN;
        res_status = STS_OK;
        open_after = open_levels_reg;
        case (item_reg.command)
            CMD_NEW_LEVEL: begin
                if (levels_full) begin
                    res_status = STS_LEVELS_FULL;
                end else begin
                    open_after = open_levels_reg + LW'(1);
                end
            end
            CMD_ASSERT: begin
                if (asrt_bad) begin
                    res_status = STS_REJECT;
                end else if (asrt_change && no_level) begin
                    res_status = STS_NO_LEVEL;
                end else if (asrt_change && trail_full) begin
                    res_status = STS_TRAIL_FULL;
                end
                if (in_range_reg) begin
                    res_entry = asrt_write ? dec_val : old_val;
                end
            end
            CMD_BACKJUMP: begin
                res_status = STS_BAD_LEVEL;
            end
            CMD_READ: begin
                if (in_range_reg) begin
                    res_entry = old_val;
                end
            end
            default: begin
                res_status = STS_OK;
            end
        endcase
    end

    // Memory port control
    always_comb begin
        mat_re    = cmd.load;
        mat_raddr = s_idx;
        mat_we    = 1'b0;
        mat_waddr = idx_reg;
        mat_wdata = dec_val;
        if (cmd.clear_step) begin
            mat_we    = 1'b1;
            mat_waddr = clr_cnt_reg;
            mat_wdata = ENT_UNKNOWN;
        end else if (cmd.undo_step && pend_reg) begin
            mat_we    = 1'b1;
            mat_waddr = trl_rdata[RW-1:2];
            mat_wdata = trl_rdata[1:0];
        end else if (cmd.commit && item_reg.command == CMD_ASSERT && asrt_write) begin
            mat_we    = 1'b1;
        end
    end

    assign trl_we    = cmd.commit && (item_reg.command == CMD_ASSERT) && asrt_write;
    assign trl_waddr = trail_count_reg[TAW-1:0];
    assign trl_wdata = {idx_reg, old_val};
    assign trl_re    = cmd.undo_step && undo_more;
    assign trl_raddr = TAW'(trail_count_reg - TCW'(1));

    assign mrk_we    = cmd.commit && (item_reg.command == CMD_NEW_LEVEL) && !levels_full;
    assign mrk_waddr = open_levels_reg[MAW-1:0];
    assign mrk_re    = cmd.load;
    assign mrk_raddr = s_tgt_p1[MAW-1:0];

    always_comb begin
        item_next        = cmd.load ? s_payload : item_reg;
        idx_next         = cmd.load ? s_idx : idx_reg;
        in_range_next    = cmd.load ? s_in_range : in_range_reg;
        trail_count_next = trail_count_reg;
        if (trl_we) begin
            trail_count_next = trail_count_reg + TCW'(1);
        end else if (trl_re) begin
            trail_count_next = trail_count_reg - TCW'(1);
        end
        undone_next = undone_reg;
        if (cmd.load) begin
            undone_next = '0;
        end else if (trl_re) begin
            undone_next = undone_reg + TCW'(1);
        end
        pend_next    = trl_re;
        clr_cnt_next = cmd.clear_step ? clr_cnt_reg + IW'(1) : clr_cnt_reg;

        open_levels_next = open_levels_reg;
        out_next         = out_reg;
        out_valid_next   = m_ready ? 1'b0 : out_valid_reg;
        if (cmd.commit) begin
            open_levels_next     = open_after;
            out_next.entry_value  = res_entry;
            out_next.status       = res_status;
            out_next.level_count  = 7'(open_after);
            out_next.undone_count = 9'd0;
            out_valid_next       = 1'b1;
        end else if (cmd.finish) begin
            open_levels_next     = LW'(tgt_p1);
            out_next.entry_value  = ENT_UNKNOWN;
            out_next.status       = STS_OK;
            out_next.level_count  = 7'(tgt_p1);
            out_next.undone_count = 9'(undone_reg);
            out_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trail_count_reg <= '0;
            open_levels_reg <= '0;
            pend_reg        <= 1'b0;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            trail_count_reg <= trail_count_next;
            open_levels_reg <= open_levels_next;
            pend_reg        <= pend_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        in_range_reg <= in_range_next;
        undone_reg   <= undone_next;
        out_reg      <= out_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    basu_ram #(.WIDTH(2), .DEPTH(CELLS)) u_matrix (
        .aclk    (aclk),
        .wr_en   (mat_we),
        .wr_addr (mat_waddr),
        .wr_data (mat_wdata),
        .rd_en   (mat_re),
        .rd_addr (mat_raddr),
        .rd_data (mat_rdata)
    );

    basu_ram #(.WIDTH(RW), .DEPTH(TRAIL_DEPTH)) u_trail (
        .aclk    (aclk),
        .wr_en   (trl_we),
        .wr_addr (trl_waddr),
        .wr_data (trl_wdata),
        .rd_en   (trl_re),
        .rd_addr (trl_raddr),
        .rd_data (trl_rdata)
    );

    basu_ram #(.WIDTH(TCW), .DEPTH(MAX_LEVELS)) u_marks (
        .aclk    (aclk),
        .wr_en   (mrk_we),
        .wr_addr (mrk_waddr),
        .wr_data (trail_count_reg),
        .rd_en   (mrk_re),
        .rd_addr (mrk_raddr),
        .rd_data (mrk_rdata)
    );

`ifndef SYNTH
    a_trail_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        trail_count_reg <= TRAIL_FULL_C)
        else $error("trail count beyond trail depth");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        open_levels_reg <= LEVELS_FULL_C)
        else $error("open levels beyond maximum");

    a_undo_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.undo_step |=> trail_count_reg <= $past(trail_count_reg))
        else $error("trail grew during a backjump");
`endif

endmodule

// ===== sv/backtrackable_adjacency_store_unit.sv =====
// Backtrackable adjacency store: a three-valued matrix (unknown, zero, one)
// kept under decision levels, with a change trail for undo.
//
// Input channel s_valid / s_ready / s_payload carries one command item:
// new level, assert edge literal, backjump or read entry. Result channel
// m_valid / m_ready / m_payload returns exactly one result item per command.
//
// Sequence: new level, assert and read are accepted, then executed on the
// registered read of the matrix or level-mark memory, and their result is
// registered in the output register. A backjump walks the trail newest
// first: the trail memory gives one record per cycle and each record costs
// one matrix write; its result follows once the walk is done.
// One item is in flight at a time; the next is accepted while a finished
// result still waits in the output register.
//
// Reset: aresetn, synchronous, active low. Afterwards the block sweeps the
// matrix to unknown, one entry a cycle (VERTEX_COUNT * VERTEX_COUNT entries,
// 256 by default), with s_ready low. A stalled receiver holds the result in
// the output register; a command then waits at its last step until it drains.
module backtrackable_adjacency_store_unit #(
    parameter int VERTEX_COUNT = basu_pkg::DEF_VERTEX_COUNT,
    parameter int TRAIL_DEPTH  = basu_pkg::DEF_TRAIL_DEPTH,
    parameter int MAX_LEVELS   = basu_pkg::DEF_MAX_LEVELS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  basu_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output basu_pkg::out_t m_payload
);
    import basu_pkg::*;

    // Command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // Sequencer: clearing sweep, accept, execute, undo walk, result hand-off
    basu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: matrix, trail and level-mark memories, counters, output item
    basu_dp #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .TRAIL_DEPTH  (TRAIL_DEPTH),
        .MAX_LEVELS   (MAX_LEVELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ===== tb/sv/tb_backtrackable_adjacency_store_unit.sv =====
`timescale 1ns / 1ps

module tb_backtrackable_adjacency_store_unit;
    import basu_pkg::*;

    localparam int NUM_V       = DEF_VERTEX_COUNT;
    localparam int NUM_CELLS   = DEF_VERTEX_COUNT * DEF_VERTEX_COUNT;
    localparam int TRAIL_MAX   = DEF_TRAIL_DEPTH;
    localparam int MAX_LV      = DEF_MAX_LEVELS;

    // Relation codes the block has no name for; both must be rejected
    localparam logic [2:0] REL_SPARE6 = 3'd6;
    localparam logic [2:0] REL_SPARE7 = 3'd7;

    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_TAIL   = 120;   // last items run with no idling on either side
    localparam int SETTLE_CYCLES = 20;
    localparam int STUCK_LIMIT  = 4000;  // covers the clearing sweep and a full-trail backjump
    localparam int PRINT_CAP    = 200;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;

    backtrackable_adjacency_store_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow of the store: matrix, change trail and level marks
    // ------------------------------------------------------------------
    logic [1:0] store_cells [NUM_CELLS];
    logic [7:0] trail_cell  [TRAIL_MAX];
    logic [1:0] trail_old   [TRAIL_MAX];
    int         level_mark  [MAX_LV];
    int         open_lv;
    int         trail_len;

    // Results still owed by the block, oldest first
    out_t pending_results [$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  items_sent     = 0;
    int  quiet_from     = 0;
    int  stuck_cycles   = 0;
    int  ready_hold     = 0;
    bit  stall_on       = 1'b1;

    // Directed stimulus: each row carries a command and, where it is obvious,
    // the result typed in by hand.
    typedef struct {
        in_t  cmd;
        bit   typed;
        out_t result;
    } dir_row_t;

    dir_row_t dir_tab [$];

    // Apply one command to the shadow store and return the result it must give.
    function automatic out_t predict_store_result(input in_t c);
        out_t       r;
        dec_t       want;
        logic [1:0] newv;
        int         slot;
        int         tgt1;
        int         undone;
        r      = '0;
        undone = 0;
        slot   = int'(c.row) * NUM_V + int'(c.column);
        case (c.command)
            CMD_NEW_LEVEL: begin
                if (open_lv >= MAX_LV) begin
                    r.status = STS_LEVELS_FULL;
                end else begin
                    level_mark[open_lv] = trail_len;
                    open_lv++;
                end
            end
            CMD_ASSERT: begin
                want = DEC_BAD;
                if (c.literal_value <= 8'd1) begin
                    case (c.relation)
                        REL_EQ:       want = c.literal_value[0] ? DEC_ONE  : DEC_ZERO;
                        REL_DISTINCT: want = c.literal_value[0] ? DEC_ZERO : DEC_ONE;
                        REL_GE:       want = c.literal_value[0] ? DEC_ONE  : DEC_KEEP;
                        REL_LE:       want = c.literal_value[0] ? DEC_KEEP : DEC_ZERO;
                        REL_GT:       want = c.literal_value[0] ? DEC_BAD  : DEC_ONE;
                        REL_LT:       want = c.literal_value[0] ? DEC_ZERO : DEC_BAD;
                        default:      want = DEC_BAD;
                    endcase
                end
                if (want == DEC_BAD) begin
                    r.status = STS_REJECT;
                end else if (want != DEC_KEEP) begin
                    newv = (want == DEC_ONE) ? ENT_ONE : ENT_ZERO;
                    if (newv != store_cells[slot]) begin
                        if (open_lv == 0) begin
                            r.status = STS_NO_LEVEL;
                        end else if (trail_len >= TRAIL_MAX) begin
                            r.status = STS_TRAIL_FULL;
                        end else begin
                            trail_cell[trail_len] = 8'(slot);
                            trail_old[trail_len]  = store_cells[slot];
                            trail_len++;
                            store_cells[slot] = newv;
                        end
                    end
                end
                r.entry_value = store_cells[slot];
            end
            CMD_BACKJUMP: begin
                tgt1 = int'(c.target_level) + 1;
                if (open_lv == 0 || tgt1 >= open_lv) begin
                    r.status = STS_BAD_LEVEL;
                end else begin
                    // unwind the trail newest first down to the mark of the level above
                    while (trail_len > level_mark[tgt1]) begin
                        trail_len--;
                        store_cells[trail_cell[trail_len]] = trail_old[trail_len];
                        undone++;
                    end
                    open_lv = tgt1;
                end
            end
            default: begin
                r.entry_value = store_cells[slot];
            end
        endcase
        r.level_count  = 7'(open_lv);
        r.undone_count = 9'(undone);
        return r;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
                           input logic [2:0] rel, input logic [7:0] lit,
                           input logic [6:0] tgt, input bit typed, input logic [1:0] ent,
                           input logic [2:0] sts, input logic [6:0] lvl,
                           input logic [8:0] und);
        dir_row_t row;
        row.cmd                  = '{op, r, c, rel, lit, tgt};
        row.typed                = typed;
        row.result               = '{ent, sts, lvl, und};
        dir_tab.insert(dir_tab.size(), row);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] result %0d: %s got %0d, expected %0d",
                     $time, results_seen, field, got, want);
    endtask

    // Offer one item, hold it until accepted, then book its expected result.
    task automatic send_command(input in_t c, input bit typed, input out_t typed_res);
        out_t predicted;
        if (items_sent >= quiet_from)
            stall_on = 1'b0;
        if (stall_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= c;
        // sample the handshake mid-cycle, where nothing is moving
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        predicted = predict_store_result(c);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        items_sent++;
    endtask

    // Hold the sender off until every owed result has come back.
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic in_t random_command();
        in_t c;
        c.command       = 2'($urandom_range(0, 3));
        c.row           = 4'($urandom_range(0, 15));
        c.column        = 4'($urandom_range(0, 15));
        c.relation      = 3'($urandom_range(0, 7));
        c.literal_value = 8'($urandom_range(0, 255));
        c.target_level  = 7'($urandom_range(0, 127));
        return c;
    endfunction

    // Mostly well-formed traffic: valid literals, backjumps to open levels,
    // a crowded corner of the matrix so that repeats and undos overlap.
    function automatic in_t mixed_command();
        in_t c;
        int  pick;
        c = random_command();
        if ($urandom_range(0, 1) == 0) begin
            c.row    = 4'($urandom_range(0, 3));
            c.column = 4'($urandom_range(0, 3));
        end
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            c.command = CMD_NEW_LEVEL;
        end else if (pick < 64) begin
            c.command = CMD_ASSERT;
            if ($urandom_range(0, 9) != 0) begin
                c.relation      = 3'($urandom_range(0, 5));
                c.literal_value = 8'($urandom_range(0, 1));
            end
        end else if (pick < 74) begin
            c.command = CMD_BACKJUMP;
            if (open_lv >= 2 && $urandom_range(0, 4) != 0)
                c.target_level = 7'($urandom_range(0, open_lv - 2));
        end else begin
            c.command = CMD_READ;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall in bursts of random length while idling is on
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (stall_on && $urandom_range(0, 4) == 0) begin
            ready_hold <= $urandom_range(0, 8);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest owed one
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : check_result
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", int'(m_payload.status), -1);
            end else begin
                want = pending_results.pop_front();
                if (m_payload.entry_value !== want.entry_value)
                    report_mismatch("entry_value", int'(m_payload.entry_value),
                                    int'(want.entry_value));
                if (m_payload.status !== want.status)
                    report_mismatch("status", int'(m_payload.status), int'(want.status));
                if (m_payload.level_count !== want.level_count)
                    report_mismatch("level_count", int'(m_payload.level_count),
                                    int'(want.level_count));
                if (m_payload.undone_count !== want.undone_count)
                    report_mismatch("undone_count", int'(m_payload.undone_count),
                                    int'(want.undone_count));
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        in_t  c;
        out_t none;
        int   target_items;
        int   burst;
        int   slot;
        int   extra;
        bit   climbed;
        bit   filled;

        none    = '0;
        climbed = 1'b0;
        filled  = 1'b0;
        for (int i = 0; i < NUM_CELLS; i++)
            store_cells[i] = ENT_UNKNOWN;
        open_lv   = 0;
        trail_len = 0;

        // Directed rows: empty store, no level, every relation, rejects,
        // a repeated write, bad backjumps and one real backjump.
        add_row(CMD_READ,      4'd0,  4'd0,  REL_EQ,       8'd0,   7'd0,   1,
                ENT_UNKNOWN, STS_OK,          7'd0, 9'd0);
        add_row(CMD_READ,      4'd15, 4'd15, REL_LT,       8'd255, 7'd127, 1,
                ENT_UNKNOWN, STS_OK,          7'd0, 9'd0);
        add_row(CMD_ASSERT,    4'd15, 4'd0,  REL_EQ,       8'd1,   7'd0,   1,
                ENT_UNKNOWN, STS_NO_LEVEL,    7'd0, 9'd0);
        add_row(CMD_ASSERT,    4'd0,  4'd15, REL_LE,       8'd1,   7'd0,   1,
                ENT_UNKNOWN, STS_OK,          7'd0, 9'd0);
        add_row(CMD_BACKJUMP,  4'd0,  4'd0,  REL_EQ,       8'd0,   7'd0,   1,
                ENT_UNKNOWN, STS_BAD_LEVEL,   7'd0, 9'd0);
        add_row(CMD_NEW_LEVEL, 4'd0,  4'd0,  REL_EQ,       8'd0,   7'd0,   1,
                ENT_UNKNOWN, STS_OK,          7'd1, 9'd0);
        add_row(CMD_BACKJUMP,  4'd0,  4'd0,  REL_EQ,       8'd0,   7'd0,   1,
                ENT_UNKNOWN, STS_BAD_LEVEL,   7'd1, 9'd0);
        add_row(CMD_ASSERT,    4'd1,  4'd2,  REL_EQ,       8'd2,   7'd0,   1,
                ENT_UNKNOWN, STS_REJECT,      7'd1, 9'd0);
        add_row(CMD_ASSERT,    4'd2,  4'd1,  REL_SPARE6,   8'd0,   7'd0,   1,
                ENT_UNKNOWN, STS_REJECT,      7'd1, 9'd0);
        add_row(CMD_ASSERT,    4'd2,  4'd1,  REL_SPARE7,   8'd1,   7'd0,   1,
                ENT_UNKNOWN, STS_REJECT,      7'd1, 9'd0);
        add_row(CMD_ASSERT,    4'd4,  4'd4,  REL_GT,       8'd1,   7'd0,   1,
                ENT_UNKNOWN, STS_REJECT,      7'd1, 9'd0);
        add_row(CMD_ASSERT,    4'd4,  4'd4,  REL_LT,       8'd0,   7'd0,   1,
                ENT_UNKNOWN, STS_REJECT,      7'd1, 9'd0);
        add_row(CMD_ASSERT,    4'd15, 4'd15, REL_EQ,       8'd1,   7'd0,   1,
                ENT_ONE,     STS_OK,          7'd1, 9'd0);
        add_row(CMD_ASSERT,    4'd15, 4'd15, REL_EQ,       8'd1,   7'd0,   1,
                ENT_ONE,     STS_OK,          7'd1, 9'd0);
        add_row(CMD_NEW_LEVEL, 4'd0,  4'd0,  REL_EQ,       8'd0,   7'd0,   1,
                ENT_UNKNOWN, STS_OK,          7'd2, 9'd0);
        add_row(CMD_ASSERT,    4'd15, 4'd15, REL_DISTINCT, 8'd1,   7'd0,   0,
                ENT_UNKNOWN, STS_OK,          7'd0, 9'd0);
        add_row(CMD_ASSERT,    4'd0,  4'd0,  REL_GE,       8'd1,   7'd0,   0,
                ENT_UNKNOWN, STS_OK,          7'd0, 9'd0);
        add_row(CMD_ASSERT,    4'd0,  4'd0,  REL_GE,       8'd0,   7'd0,   0,
                ENT_UNKNOWN, STS_OK,          7'd0, 9'd0);
        add_row(CMD_ASSERT,    4'd3,  4'd7,  REL_LE,       8'd0,   7'd0,   0,
                ENT_UNKNOWN, STS_OK,          7'd0, 9'd0);
        add_row(CMD_ASSERT,    4'd7,  4'd3,  REL_GT,       8'd0,   7'd0,   0,
                ENT_UNKNOWN, STS_OK,          7'd0, 9'd0);
        add_row(CMD_ASSERT,    4'd10, 4'd5,  REL_LT,       8'd1,   7'd0,   0,
                ENT_UNKNOWN, STS_OK,          7'd0, 9'd0);
        add_row(CMD_ASSERT,    4'd9,  4'd9,  REL_EQ,       8'd255, 7'd0,   1,
                ENT_UNKNOWN, STS_REJECT,      7'd2, 9'd0);
        add_row(CMD_BACKJUMP,  4'd0,  4'd0,  REL_EQ,       8'd0,   7'd127, 1,
                ENT_UNKNOWN, STS_BAD_LEVEL,   7'd2, 9'd0);
        add_row(CMD_BACKJUMP,  4'd0,  4'd0,  REL_EQ,       8'd0,   7'd0,   0,
                ENT_UNKNOWN, STS_OK,          7'd0, 9'd0);
        add_row(CMD_READ,      4'd15, 4'd15, REL_EQ,       8'd0,   7'd0,   0,
                ENT_UNKNOWN, STS_OK,          7'd0, 9'd0);

        target_items = dir_tab.size() + RANDOM_ITEMS;
        quiet_from   = target_items - QUIET_TAIL;

        // Hold reset, then release it; the block then sweeps its matrix
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            send_command(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].result);

        // Pause the sender until the directed results have all drained
        wait_drain();

        while (items_sent < target_items) begin
            stall_on = ($urandom_range(0, 3) != 0);
            if (!climbed && items_sent > 300) begin
                // Open levels past the limit, then drop back near the bottom
                climbed = 1'b1;
                repeat (MAX_LV - open_lv + 2) begin
                    c         = random_command();
                    c.command = CMD_NEW_LEVEL;
                    send_command(c, 1'b0, none);
                end
                c              = random_command();
                c.command      = CMD_BACKJUMP;
                c.target_level = 7'($urandom_range(0, 3));
                send_command(c, 1'b0, none);
            end else if (!filled && items_sent > 500) begin
                // Fill the trail with real changes, overrun it, then unwind
                filled = 1'b1;
                wait_drain();
                while (open_lv < 2) begin
                    c         = random_command();
                    c.command = CMD_NEW_LEVEL;
                    send_command(c, 1'b0, none);
                end
                extra = 0;
                while (extra < 3) begin
                    if (trail_len >= TRAIL_MAX)
                        extra++;
                    c               = random_command();
                    slot            = $urandom_range(0, NUM_CELLS - 1);
                    c.command       = CMD_ASSERT;
                    c.row           = 4'(slot / NUM_V);
                    c.column        = 4'(slot % NUM_V);
                    c.relation      = REL_EQ;
                    c.literal_value = (store_cells[slot] == ENT_ONE) ? 8'd0 : 8'd1;
                    send_command(c, 1'b0, none);
                end
                c              = random_command();
                c.command      = CMD_BACKJUMP;
                c.target_level = 7'($urandom_range(0, open_lv - 2));
                send_command(c, 1'b0, none);
            end else begin
                burst = $urandom_range(10, 40);
                repeat (burst) begin
                    c = mixed_command();
                    send_command(c, 1'b0, none);
                end
            end
        end

        // Drain, let any stray result show, then give the verdict
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== backtrackable_adjacency_store_unit.f =====
sv/basu_pkg.sv
sv/basu_ram.sv
sv/basu_ctrl.sv
sv/basu_dp.sv
sv/backtrackable_adjacency_store_unit.sv
tb/sv/tb_backtrackable_adjacency_store_unit.sv
